// ===== rtl/sort_with_permutation_parity_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorter RTL.
// ----------------------------------------------------------------------------
`ifndef SORT_WITH_PERMUTATION_PARITY_MACROS_SVH
`define SORT_WITH_PERMUTATION_PARITY_MACROS_SVH

// generic clocked assertion with synchronous reset disable
`define SWPP_ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// default clock and reset of the block
`define SWPP_ASSERT(lbl, prop, msg) \
   `SWPP_ASSERT_AT(lbl, clock, reset, prop, msg)

`endif

// ===== rtl/swpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorter package
// Widths, defaults, sequencer states and compare unit control.
// ----------------------------------------------------------------------------
package swpp_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int NUMBER_BITS_DEF = 8;
   localparam int SPACE_W         = 3;
   localparam int POS_W           = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_SORT_LD,
      ST_SORT_KEY,
      ST_SORT_SCAN,
      ST_OUT_ORD,
      ST_OUT_ENT,
      ST_OUT_LOAD
   } state_type;

   typedef struct packed {
      logic clr;
      logic en;
      logic tie_en;
   } cmp_ctrl_type;

endpackage

// ===== rtl/swpp_if.sv =====
// ----------------------------------------------------------------------------
// Sorter channels
// Label input channel and sorted entry output channel.
// ----------------------------------------------------------------------------
interface swpp_req_if #(
   parameter int NUMBER_BITS = swpp_pkg::NUMBER_BITS_DEF
);
   import swpp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SPACE_W-1:0]     space_id;
   logic [NUMBER_BITS-1:0] label_number;
   logic                   is_final;

   modport source (output valid, space_id, label_number, is_final, input ready);
   modport sink   (input valid, space_id, label_number, is_final, output ready);
endinterface

interface swpp_rsp_if #(
   parameter int NUMBER_BITS = swpp_pkg::NUMBER_BITS_DEF
);
   import swpp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SPACE_W-1:0]     sorted_space;
   logic [NUMBER_BITS-1:0] sorted_number;
   logic [POS_W-1:0]       source_position;
   logic                   odd_parity;
   logic                   dropped;
   logic                   end_of_list;

   modport source (output valid, sorted_space, sorted_number, source_position,
                   odd_parity, dropped, end_of_list, input ready);
   modport sink   (input valid, sorted_space, sorted_number, source_position,
                   odd_parity, dropped, end_of_list, output ready);
endinterface

// ===== rtl/sort_with_permutation_parity.sv =====
// ----------------------------------------------------------------------------
// Stable descending label sorter with permutation parity
//
// req_ch takes one label word per handshake: space, number and a final mark.
// Labels are stored in load order; each insert scans the labels already
// stored through the shared compare unit, and ready stays low from the
// handshake until that scan is done. A label that finds the store full is
// dropped and flagged, and ready stays high unless it is the final word.
// The final word starts the sort: every entry is ranked by a full scan of
// the store, one compare per cycle through the single read port of the
// entry memory. rsp_ch then gives one word per entry in sorted order, each
// fetched through the order memory and then the entry memory, with its load
// position, the parity and the drop flag; end_of_list marks the last word.
// The output register holds a word while rsp_ch.ready is low; the next word
// is fetched but waits to load behind it. Once the last word is loaded req_ch
// is ready again. Reset (synchronous) empties the list and clears parity and
// drop flag; the entry and order memories need no clearing.
// ----------------------------------------------------------------------------
`include "sort_with_permutation_parity_macros.svh"

module sort_with_permutation_parity #(
   parameter int MAX_ENTRIES = swpp_pkg::MAX_ENTRIES_DEF,
   parameter int NUMBER_BITS = swpp_pkg::NUMBER_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   swpp_req_if.sink   req_ch,
   swpp_rsp_if.source rsp_ch
);
   import swpp_pkg::*;

   localparam int KEY_W = SPACE_W + NUMBER_BITS;
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int EXT_W = IDX_W + POS_W;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             parity_ff, parity_in;
   logic             overflow_ff, overflow_in;
   logic             final_ff, final_in;
   logic [KEY_W-1:0] new_key_ff, new_key_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] r_ff, r_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [KEY_W-1:0] key_i_ff, key_i_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [SPACE_W-1:0]     out_space_ff;
   logic [NUMBER_BITS-1:0] out_number_ff;
   logic [POS_W-1:0] out_pos_ff;
   logic             out_parity_ff;
   logic             out_drop_ff;
   logic             out_eol_ff;

   logic [KEY_W-1:0] entry_mem [MAX_ENTRIES];
   logic [KEY_W-1:0] ent_rd_ff;
   logic [IDX_W-1:0] order_mem [MAX_ENTRIES];
   logic [IDX_W-1:0] ord_rd_ff;

   logic             ent_we, ent_re, ord_we, ord_re;
   logic [IDX_W-1:0] ent_wa, ent_ra, ord_wa, ord_ra, ord_wd;

   cmp_ctrl_type     cmp_ctrl;
   logic [KEY_W-1:0] cmp_a_key;
   logic [IDX_W-1:0] cmp_a_idx;
   logic [CNT_W-1:0] acc;

   logic             req_fire, rsp_fire;
   logic             issue, scan_done, sort_done, out_load, out_last;
   logic [EXT_W-1:0] src_ext;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_valid_ff && rsp_ch.ready;
   assign out_last     = (r_ff + CNT_W'(1)) == count_ff;
   assign src_ext      = {{POS_W{1'b0}}, ord_rd_ff};

   swpp_cmp_acc #(
      .KEY_W (KEY_W),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_cmp (
      .clock (clock),
      .reset (reset),
      .ctrl  (cmp_ctrl),
      .a_key (cmp_a_key),
      .a_idx (cmp_a_idx),
      .b_key ((state_ff == ST_SORT_SCAN) ? key_i_ff : ent_rd_ff),
      .b_idx (i_ff[IDX_W-1:0]),
      .count (acc)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      parity_in    = parity_ff;
      overflow_in  = overflow_ff;
      final_in     = final_ff;
      new_key_in   = new_key_ff;
      lim_in       = lim_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      r_in         = r_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      key_i_in     = key_i_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      ent_we       = 1'b0;
      ent_wa       = count_ff[IDX_W-1:0];
      ent_re       = 1'b0;
      ent_ra       = j_ff[IDX_W-1:0];
      ord_we       = 1'b0;
      ord_wa       = acc[IDX_W-1:0];
      ord_wd       = i_ff[IDX_W-1:0];
      ord_re       = 1'b0;
      ord_ra       = r_ff[IDX_W-1:0];
      cmp_ctrl     = '0;
      cmp_a_key    = new_key_ff;
      cmp_a_idx    = rd_idx_ff;
      issue        = 1'b0;
      scan_done    = 1'b0;
      sort_done    = 1'b0;
      out_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               new_key_in = {req_ch.space_id, req_ch.label_number};
               final_in   = req_ch.is_final;
               if (count_ff < CNT_W'(MAX_ENTRIES)) begin
                  ent_we       = 1'b1;
                  lim_in       = count_ff;
                  count_in     = count_ff + CNT_W'(1);
                  j_in         = '0;
                  cmp_ctrl.clr = 1'b1;
                  state_in     = ST_INS_SCAN;
               end else begin
                  overflow_in = 1'b1;
                  if (req_ch.is_final) begin
                     i_in     = '0;
                     state_in = ST_SORT_LD;
                  end
               end
            end
         end
         ST_INS_SCAN: begin
            issue       = j_ff < lim_ff;
            cmp_ctrl.en = rd_vld_ff;
            if (issue) begin
               ent_re    = 1'b1;
               j_in      = j_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = j_ff[IDX_W-1:0];
            end
            scan_done = !issue && !rd_vld_ff;
            if (scan_done) begin
               parity_in = parity_ff ^ acc[0];
               if (final_ff) begin
                  i_in     = '0;
                  state_in = ST_SORT_LD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SORT_LD: begin
            ent_re   = 1'b1;
            ent_ra   = i_ff[IDX_W-1:0];
            state_in = ST_SORT_KEY;
         end
         ST_SORT_KEY: begin
            key_i_in     = ent_rd_ff;
            j_in         = '0;
            cmp_ctrl.clr = 1'b1;
            state_in     = ST_SORT_SCAN;
         end
         ST_SORT_SCAN: begin
            issue           = j_ff < count_ff;
            cmp_ctrl.en     = rd_vld_ff;
            cmp_ctrl.tie_en = 1'b1;
            cmp_a_key       = ent_rd_ff;
            if (issue) begin
               ent_re    = 1'b1;
               j_in      = j_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = j_ff[IDX_W-1:0];
            end
            sort_done = !issue && !rd_vld_ff;
            if (sort_done) begin
               ord_we = 1'b1;
               if ((i_ff + CNT_W'(1)) == count_ff) begin
                  r_in     = '0;
                  state_in = ST_OUT_ORD;
               end else begin
                  i_in     = i_ff + CNT_W'(1);
                  state_in = ST_SORT_LD;
               end
            end
         end
         ST_OUT_ORD: begin
            ord_re   = 1'b1;
            state_in = ST_OUT_ENT;
         end
         ST_OUT_ENT: begin
            ent_re   = 1'b1;
            ent_ra   = ord_rd_ff;
            state_in = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (out_last) begin
                  count_in    = '0;
                  parity_in   = 1'b0;
                  overflow_in = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  r_in     = r_ff + CNT_W'(1);
                  state_in = ST_OUT_ORD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         parity_ff    <= 1'b0;
         overflow_ff  <= 1'b0;
         final_ff     <= 1'b0;
         lim_ff       <= '0;
         j_ff         <= '0;
         i_ff         <= '0;
         r_ff         <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         parity_ff    <= parity_in;
         overflow_ff  <= overflow_in;
         final_ff     <= final_in;
         lim_ff       <= lim_in;
         j_ff         <= j_in;
         i_ff         <= i_in;
         r_ff         <= r_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_key_ff <= new_key_in;
      rd_idx_ff  <= rd_idx_in;
      key_i_ff   <= key_i_in;
      if (out_load) begin
         out_space_ff  <= ent_rd_ff[KEY_W-1:NUMBER_BITS];
         out_number_ff <= ent_rd_ff[NUMBER_BITS-1:0];
         out_pos_ff    <= src_ext[POS_W-1:0];
         out_parity_ff <= parity_ff;
         out_drop_ff   <= overflow_ff;
         out_eol_ff    <= out_last;
      end
   end

   // entry store: one write, one registered read
   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[ent_wa] <= {req_ch.space_id, req_ch.label_number};
      end
      if (ent_re) begin
         ent_rd_ff <= entry_mem[ent_ra];
      end
   end

   // rank to source index map
   always_ff @(posedge clock) begin
      if (ord_we) begin
         order_mem[ord_wa] <= ord_wd;
      end
      if (ord_re) begin
         ord_rd_ff <= order_mem[ord_ra];
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.sorted_space    = out_space_ff;
   assign rsp_ch.sorted_number   = out_number_ff;
   assign rsp_ch.source_position = out_pos_ff;
   assign rsp_ch.odd_parity      = out_parity_ff;
   assign rsp_ch.dropped         = out_drop_ff;
   assign rsp_ch.end_of_list     = out_eol_ff;

   `SWPP_ASSERT(a_insert_count,
      (req_fire && (count_ff < CNT_W'(MAX_ENTRIES))) |=>
      (count_ff == $past(count_ff) + CNT_W'(1)),
      "insert did not advance entry count")
   `SWPP_ASSERT(a_rank_range, sort_done |-> (acc < count_ff), "rank beyond list length")
   `SWPP_ASSERT(a_rd_in_scan,
      rd_vld_ff |-> ((state_ff == ST_INS_SCAN) || (state_ff == ST_SORT_SCAN)),
      "read data outside a scan")
   `SWPP_ASSERT(a_list_clear,
      (out_load && out_last) |=> ((count_ff == '0) && !parity_ff && !overflow_ff),
      "list state not cleared after last word")

endmodule

// ===== rtl/swpp_cmp_acc.sv =====
// ----------------------------------------------------------------------------
// Compare and count unit
// Counts the enabled cycles in which key a sorts ahead of key b, with optional
// load order tie break.
// ----------------------------------------------------------------------------
module swpp_cmp_acc #(
   parameter int KEY_W = 11,
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  swpp_pkg::cmp_ctrl_type ctrl,
   input  logic [KEY_W-1:0]      a_key,
   input  logic [IDX_W-1:0]      a_idx,
   input  logic [KEY_W-1:0]      b_key,
   input  logic [IDX_W-1:0]      b_idx,
   output logic [CNT_W-1:0]      count
);
   import swpp_pkg::*;

   logic             hit;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign hit = (a_key > b_key) || (ctrl.tie_en && (a_key == b_key) && (a_idx < b_idx));

   always_comb begin
      if (ctrl.clr) begin
         count_in = '0;
      end else if (ctrl.en && hit) begin
         count_in = count_ff + CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// ===== tb/sort_with_permutation_parity_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Label sorter testbench
// Sends lists of (space, number) labels, some of them past the store capacity.
// For every list a scoreboard works out the stable descending order, the
// load positions, the permutation parity and the drop flag. Each sorted word
// is checked field by field against the scoreboard. Both channels idle at
// random. The output side is also held off for long stretches, so that the
// sorter backs up into its input.
// ----------------------------------------------------------------------------
module sort_with_permutation_parity_tb;
   import swpp_pkg::*;

   localparam int CAPACITY    = MAX_ENTRIES_DEF;
   localparam int NUM_W       = NUMBER_BITS_DEF;
   localparam int KEY_W       = SPACE_W + NUM_W;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 64;
   localparam int HOLD_CYCLES = 400;
   localparam int LABEL_GOAL  = 380;

   typedef struct packed {
      logic [SPACE_W-1:0] sorted_space;
      logic [NUM_W-1:0]   sorted_number;
      logic [POS_W-1:0]   source_position;
      logic               odd_parity;
      logic               dropped;
      logic               end_of_list;
   } sorted_word_type;

   class label_sort_board;
      logic [KEY_W-1:0] keys[CAPACITY];
      int               stored   = 0;
      logic             odd      = 1'b0;
      logic             overflow = 1'b0;
      sorted_word_type  expected_words[$];
      int               errors   = 0;
      int               checked  = 0;

      function void note_label(logic [SPACE_W-1:0] sp, logic [NUM_W-1:0] num, logic fin);
         logic [KEY_W-1:0] key;
         int               ahead;
         int               rank;
         int               order[CAPACITY];
         sorted_word_type  w;
         key = {sp, num};
         if (stored < CAPACITY) begin
            ahead = 0;
            for (int i = 0; i < stored; i++) begin
               if (key > keys[i]) ahead++;
            end
            odd ^= ahead[0];
            keys[stored] = key;
            stored++;
         end else begin
            overflow = 1'b1;
         end
         if (!fin) return;
         for (int i = 0; i < stored; i++) begin
            rank = 0;
            for (int j = 0; j < stored; j++) begin
               if (keys[j] > keys[i] || (keys[j] == keys[i] && j < i)) rank++;
            end
            order[rank] = i;
         end
         for (int i = 0; i < stored; i++) begin
            w.sorted_space    = keys[order[i]][KEY_W-1:NUM_W];
            w.sorted_number   = keys[order[i]][NUM_W-1:0];
            w.source_position = POS_W'(order[i]);
            w.odd_parity      = odd;
            w.dropped         = overflow;
            w.end_of_list     = (i == stored - 1);
            expected_words    = {expected_words, w};
         end
         stored   = 0;
         odd      = 1'b0;
         overflow = 1'b0;
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(sorted_word_type got);
         sorted_word_type want;
         if (expected_words.size() == 0) begin
            $error("sorted word with none expected: %p", got);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         checked++;
         compare_field("sorted_space", 16'(want.sorted_space), 16'(got.sorted_space));
         compare_field("sorted_number", 16'(want.sorted_number), 16'(got.sorted_number));
         compare_field("source_position", 16'(want.source_position),
                       16'(got.source_position));
         compare_field("odd_parity", 16'(want.odd_parity), 16'(got.odd_parity));
         compare_field("dropped", 16'(want.dropped), 16'(got.dropped));
         compare_field("end_of_list", 16'(want.end_of_list), 16'(got.end_of_list));
      endfunction
   endclass

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   int unsigned     cycle_count = 0;
   int              send_calm   = 0;
   int              recv_calm   = 0;
   int              labels_sent = 0;
   int              lists_sent  = 0;
   int              overfull    = 0;
   label_sort_board board;

   swpp_req_if req_ch ();
   swpp_rsp_if rsp_ch ();

   sort_with_permutation_parity dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("sort_with_permutation_parity_tb: errors");
      $finish;
   end

   // idle gap with occasional runs of back-to-back words
   function automatic int draw_gap(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm_left = $urandom_range(4, 24);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   task automatic send_label(input logic [SPACE_W-1:0] sp, input logic [NUM_W-1:0] num,
                             input logic fin);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.space_id     <= sp;
      req_ch.label_number <= num;
      req_ch.is_final     <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_label(sp, num, fin);
      labels_sent++;
      if (fin) lists_sent++;
   endtask

   task automatic send_list(input int len, input int flavor);
      logic [SPACE_W-1:0] sp;
      logic [NUM_W-1:0]   num;
      if (len > CAPACITY) overfull++;
      for (int i = 0; i < len; i++) begin
         case (flavor)
            0: begin
               sp  = SPACE_W'($urandom_range(0, 7));
               num = NUM_W'($urandom_range(0, 255));
            end
            1: begin
               sp  = SPACE_W'($urandom_range(0, 1));
               num = NUM_W'($urandom_range(0, 3));
            end
            2: begin
               sp  = SPACE_W'($urandom_range(0, 7));
               num = $urandom_range(0, 2) == 0 ? 8'd0 :
                     $urandom_range(0, 1) == 0 ? 8'd255 : NUM_W'($urandom_range(0, 255));
            end
            default: begin
               sp  = $urandom_range(0, 1) ? 3'd7 : 3'd0;
               num = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
         endcase
         send_label(sp, num, i == len - 1);
      end
   endtask

   initial begin : receiver
      int              gap;
      int              words_seen;
      sorted_word_type got;
      words_seen = 0;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         gap = draw_gap(recv_calm);
         if (words_seen == 40 || words_seen == 200) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got.sorted_space    = rsp_ch.sorted_space;
         got.sorted_number   = rsp_ch.sorted_number;
         got.source_position = rsp_ch.source_position;
         got.odd_parity      = rsp_ch.odd_parity;
         got.dropped         = rsp_ch.dropped;
         got.end_of_list     = rsp_ch.end_of_list;
         board.check_word(got);
         words_seen++;
      end
   end

   initial begin : stimulus
      int len;
      int pick;
      board = new();
      req_ch.valid        <= 1'b0;
      req_ch.space_id     <= '0;
      req_ch.label_number <= '0;
      req_ch.is_final     <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // one-label list
      send_label(3'd7, 8'd255, 1'b1);
      // extremes and equal labels
      send_label(3'd0, 8'd0,   1'b0);
      send_label(3'd7, 8'd255, 1'b0);
      send_label(3'd0, 8'd0,   1'b0);
      send_label(3'd3, 8'd128, 1'b0);
      send_label(3'd7, 8'd255, 1'b0);
      send_label(3'd5, 8'd1,   1'b1);
      // overfull list with repeats; the final label itself is dropped
      overfull++;
      for (int i = 0; i < CAPACITY + 2; i++) begin
         send_label(SPACE_W'((i % 3) * 3), NUM_W'((i % 6) * 51), i == CAPACITY + 1);
      end

      while (labels_sent < LABEL_GOAL) begin
         pick = $urandom_range(0, 9);
         if (pick < 7)      len = $urandom_range(1, 6);
         else if (pick < 9) len = $urandom_range(7, CAPACITY);
         else               len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
         send_list(len, $urandom_range(0, 3));
      end
      req_ch.valid <= 1'b0;

      while (board.expected_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d labels in %0d lists sent, %0d of the lists overfull",
               labels_sent, lists_sent, overfull);
      $display("%0d sorted words checked, %0d mismatches", board.checked, board.errors);
      if (board.errors == 0 && board.expected_words.size() == 0) begin
         $display("sort_with_permutation_parity_tb: clean");
      end else begin
         $display("sort_with_permutation_parity_tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/swpp_pkg.sv
rtl/swpp_if.sv
rtl/swpp_cmp_acc.sv
rtl/sort_with_permutation_parity.sv
tb/sort_with_permutation_parity_tb.sv
